>>> hdl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/lcp_pkg.sv
// types and constants for the lfu cache policy block
// no dependencies
package lcp_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int CSR_W        = 5;
   localparam logic [CSR_W-1:0] CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic               op;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] value;
      logic [31:0] freq;
      logic [63:0] stamp;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic look;
      logic update;
      logic scan_issue;
      logic insert;
      logic evict;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cap_zero;
      logic hit;
      logic op_put;
      logic full;
      logic scan_last;
   } sts_type;

endpackage

>>> hdl/lcp_datapath.sv
// entry storage, parallel key compare, victim scan and result registers
// depends on lcp_pkg
module lcp_datapath #(
   parameter int CAPACITY = lcp_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lcp_pkg::req_type              req_payload,
   input  logic                          csr_valid,
   input  logic [lcp_pkg::CSR_W-1:0]     csr_data,
   input  lcp_pkg::cmd_type              cmd,
   output lcp_pkg::sts_type              sts,
   output lcp_pkg::rsp_type              rsp_payload
);
   import lcp_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW    = ($clog2(CAPACITY + 1) > CSR_W) ? $clog2(CAPACITY + 1) : CSR_W;

   // configuration and control state
   logic [CSR_W-1:0]    cap_ff;
   logic [CW-1:0]       count_ff;
   logic [63:0]         clock_cnt_ff;
   logic [CAPACITY-1:0] valid_ff;

   // latched request
   req_type             item_ff;

   // key cells, each compared at its own place
   logic [31:0]         key_cell_ff [CAPACITY];

   // entry memory, one write and one registered read
   entry_type           mem [CAPACITY];
   entry_type           rd_q_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;

   // lookup results
   logic [CAPACITY-1:0] hit_vec;
   logic                hit_any_c;
   logic [IDX_W-1:0]    hit_idx_c;
   logic [IDX_W-1:0]    free_idx_c;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic [IDX_W-1:0]    free_idx_ff;

   // victim scan
   logic [IDX_W-1:0]    scan_cnt_ff;
   logic                pend_ff;
   logic [IDX_W-1:0]    pend_idx_ff;
   logic                best_found_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [31:0]         best_freq_ff;
   logic [63:0]         best_stamp_ff;
   logic [31:0]         best_key_ff;
   logic                better_c;

   // results
   rsp_type             res_ff;
   rsp_type             rsp_ff;

   logic [CW-1:0]       cap_wide;
   logic [CW-1:0]       cap_eff;
   logic [63:0]         stamp_next;
   logic [31:0]         freq_next;
   logic [IDX_W-1:0]    ins_idx;

   assign cap_wide   = CW'(cap_ff);
   assign cap_eff    = (cap_wide > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_wide;
   assign stamp_next = clock_cnt_ff + 64'd1;
   assign freq_next  = (rd_q_ff.freq == 32'hFFFF_FFFF) ? rd_q_ff.freq : rd_q_ff.freq + 32'd1;
   assign ins_idx    = cmd.evict ? best_idx_ff : free_idx_ff;

   always_comb begin
      hit_idx_c  = '0;
      free_idx_c = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         hit_vec[i] = valid_ff[i] && (key_cell_ff[i] == item_ff.key);
         if (hit_vec[i]) begin
            hit_idx_c = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx_c = IDX_W'(i);
         end
      end
   end

   assign hit_any_c = |hit_vec;

   assign sts.cap_zero  = (cap_eff == '0);
   assign sts.hit       = hit_any_c;
   assign sts.op_put    = (item_ff.op == OP_PUT);
   assign sts.full      = (count_ff >= cap_eff);
   assign sts.scan_last = (scan_cnt_ff == IDX_W'(CAPACITY - 1));

   assign rd_addr = cmd.scan_issue ? scan_cnt_ff : hit_idx_c;

   // smaller count wins, then older stamp, lowest slot on a full tie
   assign better_c = !best_found_ff || (rd_q_ff.freq < best_freq_ff) ||
                     ((rd_q_ff.freq == best_freq_ff) && (rd_q_ff.stamp < best_stamp_ff));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = hit_idx_ff;
      wr_data = rd_q_ff;
      if (cmd.update) begin
         wr_en         = 1'b1;
         wr_data.freq  = freq_next;
         wr_data.stamp = stamp_next;
         if (item_ff.op == OP_PUT) begin
            wr_data.value = item_ff.value;
         end
      end else if (cmd.insert) begin
         wr_en         = 1'b1;
         wr_addr       = ins_idx;
         wr_data.key   = item_ff.key;
         wr_data.value = item_ff.value;
         wr_data.freq  = 32'd1;
         wr_data.stamp = stamp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         count_ff      <= '0;
         clock_cnt_ff  <= '0;
         valid_ff      <= '0;
         pend_ff       <= 1'b0;
         best_found_ff <= 1'b0;
         scan_cnt_ff   <= '0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         pend_ff <= cmd.scan_issue;
         if (cmd.load) begin
            scan_cnt_ff   <= '0;
            best_found_ff <= 1'b0;
         end else if (cmd.scan_issue) begin
            scan_cnt_ff <= scan_cnt_ff + IDX_W'(1);
         end
         if (pend_ff && valid_ff[pend_idx_ff] && better_c) begin
            best_found_ff <= 1'b1;
         end
         if (cmd.update) begin
            clock_cnt_ff <= stamp_next;
         end
         if (cmd.insert) begin
            clock_cnt_ff       <= stamp_next;
            valid_ff[ins_idx]  <= 1'b1;
            if (!cmd.evict) begin
               count_ff <= count_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= scan_cnt_ff;
      if (cmd.load) begin
         item_ff <= req_payload;
         res_ff  <= '0;
      end
      if (cmd.look) begin
         hit_idx_ff  <= hit_idx_c;
         free_idx_ff <= free_idx_c;
      end
      if (pend_ff && valid_ff[pend_idx_ff] && better_c) begin
         best_idx_ff   <= pend_idx_ff;
         best_freq_ff  <= rd_q_ff.freq;
         best_stamp_ff <= rd_q_ff.stamp;
         best_key_ff   <= rd_q_ff.key;
      end
      if (cmd.update) begin
         res_ff.hit <= 1'b1;
         if (item_ff.op == OP_GET) begin
            res_ff.read_value <= rd_q_ff.value;
         end
      end
      if (cmd.insert) begin
         key_cell_ff[ins_idx] <= item_ff.key;
         if (cmd.evict) begin
            res_ff.evicted     <= 1'b1;
            res_ff.evicted_key <= best_key_ff;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

>>> hdl/lcp_ctrl.sv
// sequencing of one access: lookup, update, victim scan, insert, response
// depends on lcp_pkg
module lcp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  lcp_pkg::sts_type sts,
   output lcp_pkg::cmd_type cmd
);
   import lcp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_UPD,
      S_SCAN,
      S_DRAIN,
      S_EVICT,
      S_INS,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            priority if (sts.cap_zero) begin
               state_in = S_DONE;
            end else if (sts.hit) begin
               state_in = S_UPD;
            end else if (!sts.op_put) begin
               state_in = S_DONE;
            end else if (sts.full) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_INS;
            end
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         // last read of the scan is compared here
         S_DRAIN: begin
            state_in = S_EVICT;
         end
         S_EVICT: begin
            cmd.insert = 1'b1;
            cmd.evict  = 1'b1;
            state_in   = S_DONE;
         end
         S_INS: begin
            cmd.insert = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

>>> hdl/lfu_cache_policy_core.sv
// top level of the lfu cache policy block: controller plus datapath
// depends on lcp_pkg, lcp_ctrl, lcp_datapath
//
// channel  direction  ports                           moves
// req      in         req_valid/req_ready/req_payload one get or put per transfer
// rsp      out        rsp_valid/rsp_ready/rsp_payload one result per request
// csr      in         csr_valid/csr_ready/csr_data    capacity_in_use write
//
// a disabled cache or a get miss goes from lookup straight to the response state, a hit goes
// via update, a free-slot put via insert, an evicting put via scan, drain and evict: the
// victim search reads the entry memory one slot per cycle through its single read port.
// reset clears the valid bits, fill count and access clock and sets capacity to 16.
// a new request is taken the cycle after the response is loaded, while it still waits.
// a response not yet taken holds the next one in the controller until the register frees.
module lfu_cache_policy_core #(
   parameter int CAPACITY = lcp_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lcp_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lcp_pkg::rsp_type          rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lcp_pkg::CSR_W-1:0] csr_data
);
   import lcp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   lcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lcp_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> hdl/lcp_checker.sv
// port-level checks for lfu_cache_policy_core, attached by bind
// depends on lcp_pkg and assert_macros.svh
`include "assert_macros.svh"

module lcp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lcp_pkg::rsp_type rsp_payload
);
   import lcp_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))
   // one access in flight at a time
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_SAME(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))
   // an eviction only comes from a put of a missing key
   `ASSERT_SAME(a_evict_miss, clock, reset, rsp_valid && rsp_payload.evicted,
                !rsp_payload.hit && (rsp_payload.read_value == 0))

endmodule

bind lfu_cache_policy_core lcp_checker u_lcp_checker (.*);
